>>> rtl/utf8d_pkg.sv
// shared types and constants of the utf-8 to code point decoder
// no dependencies; imported by every module of the block
package utf8d_pkg;

    localparam int CODE_W  = 21;   // code point / code unit width
    localparam int BYTE_W  = 8;
    localparam int RES_MAX = 3;    // most results one byte can cause
    localparam int CNT_W   = 2;    // holds 0 .. RES_MAX

    localparam logic [CODE_W-1:0] SUPP_BASE = 21'h10000;
    localparam logic [15:0]       HI_SURR   = 16'hD800;
    localparam logic [15:0]       LO_SURR   = 16'hDC00;

    localparam logic [4:0] LEAD2_MASK = 5'h1F;
    localparam logic [3:0] LEAD3_MASK = 4'h0F;
    localparam logic [2:0] LEAD4_MASK = 3'h07;
    localparam logic [5:0] CONT_MASK  = 6'h3F;

    typedef enum logic [1:0] {
        KIND_UNIT = 2'd0,
        KIND_OK   = 2'd1,
        KIND_BAD  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [CODE_W-1:0] unit;
        t_kind             kind;
    } t_result;

    typedef struct packed {
        logic [CODE_W-1:0] partial;
        logic [1:0]        remain;
        logic              err;
    } t_dec_state;

endpackage

>>> rtl/utf8d_decode.sv
// per-byte decode step: next decoder state and up to three results
// depends on utf8d_pkg
module utf8d_decode (
    input  logic [utf8d_pkg::BYTE_W-1:0]                     i_byte,
    input  logic                                             i_last,
    input  logic                                             i_utf16,
    input  utf8d_pkg::t_dec_state                            i_state,
    output utf8d_pkg::t_dec_state                            o_state,
    output logic [utf8d_pkg::CNT_W-1:0]                      o_count,
    output utf8d_pkg::t_result [utf8d_pkg::RES_MAX-1:0]      o_res
);
    import utf8d_pkg::*;

    t_dec_state        s;
    logic              emit;
    logic [CODE_W-1:0] cp;
    logic [CODE_W-1:0] d;
    logic [15:0]       hi;
    logic [15:0]       lo;
    logic [1:0]        n_emit;
    logic [CODE_W-1:0] e0;
    logic [CODE_W-1:0] e1;
    t_result           status;
    logic              bad;

    always_comb begin
        s    = i_state;
        emit = 1'b0;
        cp   = '0;
        if (!i_state.err) begin
            if (i_state.remain == 2'd0) begin
                priority if (i_byte[7] == 1'b0) begin
                    emit = 1'b1;
                    cp   = {{(CODE_W-BYTE_W){1'b0}}, i_byte};
                end else if (i_byte[7:5] == 3'b110) begin
                    s.partial = {{(CODE_W-5){1'b0}}, i_byte[4:0] & LEAD2_MASK};
                    s.remain  = 2'd1;
                end else if (i_byte[7:4] == 4'b1110) begin
                    s.partial = {{(CODE_W-4){1'b0}}, i_byte[3:0] & LEAD3_MASK};
                    s.remain  = 2'd2;
                end else if (i_byte[7:3] == 5'b11110) begin
                    s.partial = {{(CODE_W-3){1'b0}}, i_byte[2:0] & LEAD4_MASK};
                    s.remain  = 2'd3;
                end else begin
                    s.err = 1'b1;
                end
            end else if (i_byte[7:6] != 2'b10) begin
                s.err = 1'b1;
            end else begin
                s.partial = {i_state.partial[CODE_W-7:0], i_byte[5:0] & CONT_MASK};
                s.remain  = i_state.remain - 2'd1;
                if (i_state.remain == 2'd1) begin
                    emit = 1'b1;
                    cp   = s.partial;
                end
            end
        end
    end

    // utf-16 split for supplementary code points
    always_comb begin
        d  = cp - SUPP_BASE;
        hi = HI_SURR + {5'b0, d[20:10]};
        lo = LO_SURR + {6'b0, d[9:0]};
        if (!emit) begin
            n_emit = 2'd0;
            e0     = cp;
            e1     = cp;
        end else if (i_utf16 && cp >= SUPP_BASE) begin
            n_emit = 2'd2;
            e0     = {5'b0, hi};
            e1     = {5'b0, lo};
        end else begin
            n_emit = 2'd1;
            e0     = cp;
            e1     = cp;
        end
    end

    // closing status and slot placement
    always_comb begin
        bad         = s.err | (s.remain != 2'd0);
        status.unit = '0;
        status.kind = bad ? KIND_BAD : KIND_OK;
        o_state     = i_last ? '0 : s;
        o_count     = n_emit + {1'b0, i_last};
        o_res[2]    = status;
        o_res[1]    = (n_emit == 2'd2) ? t_result'{unit: e1, kind: KIND_UNIT} : status;
        o_res[0]    = (n_emit != 2'd0) ? t_result'{unit: e0, kind: KIND_UNIT} : status;
    end

endmodule

>>> rtl/utf8d_outq.sv
// result register: holds the results of one byte and hands them out one per beat
// depends on utf8d_pkg
module utf8d_outq (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_load,
    input  logic [utf8d_pkg::CNT_W-1:0]                  i_count,
    input  utf8d_pkg::t_result [utf8d_pkg::RES_MAX-1:0]  i_res,
    input  logic                                         i_pop_ready,
    output logic                                         o_valid,
    output utf8d_pkg::t_result                           o_head,
    output logic                                         o_last,
    output logic                                         o_can_load
);
    import utf8d_pkg::*;

    t_result [RES_MAX-1:0] r_res;
    t_result [RES_MAX-1:0] n_res;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  pop;

    assign o_valid    = (r_count != '0);
    assign o_head     = r_res[0];
    assign o_last     = (r_count == CNT_W'(1));
    assign pop        = o_valid & i_pop_ready;
    assign o_can_load = !o_valid || (o_last && i_pop_ready);

    always_comb begin
        n_res   = r_res;
        n_count = r_count;
        if (i_load) begin
            n_res   = i_res;
            n_count = i_count;
        end else if (pop) begin
            n_res[RES_MAX-2:0] = r_res[RES_MAX-1:1];
            n_count            = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        r_res <= n_res;
    end

endmodule

>>> rtl/utf8_to_codepoint_decoder.sv
// top level of the lax utf-8 to code point decoder
// depends on utf8d_pkg, utf8d_decode and utf8d_outq
//
// One byte beat goes in per cycle while input ready is high. The byte is
// decoded at once against the held decoder state (partial code point,
// continuation bytes still due, sticky error) and its results land in a
// result register of three slots, which hands them out one beat per cycle
// while output ready is high, with last_of_run on the final one. A
// supplementary code point in utf-16 mode or a final byte that also completes
// a character causes two or three results, and input ready then drops while
// the result register drains. The next byte is taken in the same cycle as the
// last result of the previous one leaves. A final byte always adds a status
// beat (ok or malformed) and clears the decoder state. Overlong forms and
// surrogates are not checked. The utf16 mode bit is written through the cfg
// channel, which is always ready; write it only while the block is idle.
module utf8_to_codepoint_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic                          i_cfg_utf16_output,
    // byte input channel
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [utf8d_pkg::BYTE_W-1:0]  i_byte_in,
    input  logic                          i_end_of_text,
    // result output channel
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [utf8d_pkg::CODE_W-1:0]  o_code_unit,
    output logic [1:0]                    o_result_kind,
    output logic                          o_last_of_run
);
    import utf8d_pkg::*;

    logic                  r_utf16;
    t_dec_state            r_state;
    t_dec_state            n_state;
    logic [CNT_W-1:0]      dec_count;
    t_result [RES_MAX-1:0] dec_res;
    t_result               head;
    logic                  in_beat;

    assign o_cfg_ready = 1'b1;
    assign in_beat     = i_in_valid & o_in_ready;

    // mode register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_utf16 <= 1'b0;
        end else if (i_cfg_valid) begin
            r_utf16 <= i_cfg_utf16_output;
        end
    end

    utf8d_decode u_decode (
        .i_byte  (i_byte_in),
        .i_last  (i_end_of_text),
        .i_utf16 (r_utf16),
        .i_state (r_state),
        .o_state (n_state),
        .o_count (dec_count),
        .o_res   (dec_res)
    );

    // decoder state advances on every accepted byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    // results of one byte, drained one beat per cycle while output ready is high
    utf8d_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (in_beat),
        .i_count     (dec_count),
        .i_res       (dec_res),
        .i_pop_ready (i_out_ready),
        .o_valid     (o_out_valid),
        .o_head      (head),
        .o_last      (o_last_of_run),
        .o_can_load  (o_in_ready)
    );

    assign o_code_unit   = head.unit;
    assign o_result_kind = head.kind;

    // a final byte leaves the decoder clean for the next text
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_end_of_text |=> r_state == '0)
        else $error("decoder state not cleared after final byte");

    // a final byte always brings at least its status beat
    a_end_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_end_of_text |=> o_out_valid)
        else $error("no result after final byte");

    // input holds while more than one result of the current byte remains
    a_stall_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_run |-> !o_in_ready)
        else $error("byte accepted while results still pending");

    // status beats carry a zero code unit and close the run
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result_kind != KIND_UNIT |-> o_last_of_run && o_code_unit == '0)
        else $error("status beat malformed");

endmodule
